// ===== rtl/core/sbo_pkg.sv =====
// Shared constants, codes and stage payload types for the sphere/box overlap test.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package sbo_pkg;

  localparam int COORD_W   = 24;                  // signed Q12.12 centre coordinate
  localparam int SIZE_W    = 20;                  // unsigned Q8.12 size lane
  localparam int NUM_AXES  = 3;
  localparam int SIZE_PK_W = NUM_AXES * SIZE_W;   // packed size word

  // doubled coordinates carry one extra fraction bit; their difference one more
  localparam int DIFF_W  = COORD_W + 2;
  localparam int ADIFF_W = COORD_W + 1;
  // doubled radius sum (sphere pair) is the widest bound
  localparam int LIM_W   = SIZE_W + 2;
  localparam int CMP_W   = (ADIFF_W > LIM_W) ? ADIFF_W : LIM_W;
  localparam int SQ_W    = 2 * LIM_W;
  localparam int SUM_W   = SQ_W + 2;

  typedef enum logic [1:0] {
    KIND_SPHERE_SPHERE = 2'd0,
    KIND_BOX_BOX       = 2'd1,
    KIND_SPHERE_BOX    = 2'd2
  } pair_kind_e;

  typedef struct packed {
    logic [1:0]                          kind;
    logic [NUM_AXES-1:0][COORD_W-1:0]    a_c;
    logic [NUM_AXES-1:0][COORD_W-1:0]    b_c;
    logic [SIZE_PK_W-1:0]                a_size;
    logic [SIZE_PK_W-1:0]                b_size;
  } item_t;

  typedef struct packed {
    logic [1:0]                        kind;
    logic                              box_hit;
    logic                              far;     // some axis delta already at or past the bound
    logic [NUM_AXES-1:0][LIM_W-1:0]    d;
    logic [LIM_W-1:0]                  lim;
  } geom_t;

  typedef struct packed {
    logic [1:0]                        kind;
    logic                              box_hit;
    logic                              far;
    logic [NUM_AXES-1:0][SQ_W-1:0]     sq;
    logic [SQ_W-1:0]                   lim_sq;
  } square_t;

endpackage

`default_nettype wire

// ===== rtl/core/sphere_box_overlap_test.sv =====
// Sphere/box overlap test: top level, input register and stage flow control.
// Depends on sbo_pkg, sbo_geom, sbo_square, sbo_decide.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one shape pair per
//   transaction: pair kind, both centres (signed Q12.12) and both packed
//   size words (three unsigned Q8.12 lanes each).
//   Output channel (out_valid_o / out_ready_i) returns one overlap bit per
//   pair, in order.
//   Pipeline: input register, geometry stage, square stage, result register.
//   One pair is accepted every cycle while the receiver keeps up; the
//   four-stage pipeline has per-stage valids, each stage loading whenever
//   the stage after it is empty or moving.
//   When the receiver stalls, bubbles are squeezed out first; in_ready_o
//   drops only once all four stages hold a pair.
//   Reset clears the stage valids only; the block keeps no other state.
`timescale 1ns / 1ps
`default_nettype none

module sphere_box_overlap_test (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic [1:0]                             pair_kind_i,
  input  wire logic signed [sbo_pkg::COORD_W-1:0]     a_center_x_i,
  input  wire logic signed [sbo_pkg::COORD_W-1:0]     a_center_y_i,
  input  wire logic signed [sbo_pkg::COORD_W-1:0]     a_center_z_i,
  input  wire logic signed [sbo_pkg::COORD_W-1:0]     b_center_x_i,
  input  wire logic signed [sbo_pkg::COORD_W-1:0]     b_center_y_i,
  input  wire logic signed [sbo_pkg::COORD_W-1:0]     b_center_z_i,
  input  wire logic [sbo_pkg::SIZE_PK_W-1:0]          a_size_i,
  input  wire logic [sbo_pkg::SIZE_PK_W-1:0]          b_size_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic                                        overlap_o
);

  logic             item_valid_q;
  sbo_pkg::item_t   item_q, item_d;
  logic             adv_in, adv_geom, adv_square, adv_out;
  logic             geom_valid, square_valid, out_valid;
  sbo_pkg::geom_t   geom;
  sbo_pkg::square_t square;

  // each stage loads when the next one is empty or moving on
  assign adv_out    = !out_valid    || out_ready_i;
  assign adv_square = !square_valid || adv_out;
  assign adv_geom   = !geom_valid   || adv_square;
  assign adv_in     = !item_valid_q || adv_geom;
  assign in_ready_o = adv_in;

  always_comb begin
    item_d        = '0;
    item_d.kind   = pair_kind_i;
    item_d.a_c[0] = a_center_x_i;
    item_d.a_c[1] = a_center_y_i;
    item_d.a_c[2] = a_center_z_i;
    item_d.b_c[0] = b_center_x_i;
    item_d.b_c[1] = b_center_y_i;
    item_d.b_c[2] = b_center_z_i;
    item_d.a_size = a_size_i;
    item_d.b_size = b_size_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (adv_in) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      item_q <= item_d;
    end
  end

  sbo_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv_geom),
    .valid_i (item_valid_q),
    .item_i  (item_q),
    .valid_o (geom_valid),
    .geom_o  (geom)
  );

  sbo_square u_square (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv_square),
    .valid_i  (geom_valid),
    .geom_i   (geom),
    .valid_o  (square_valid),
    .square_o (square)
  );

  sbo_decide u_decide (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv_out),
    .valid_i   (square_valid),
    .square_i  (square),
    .valid_o   (out_valid),
    .overlap_o (overlap_o)
  );

  assign out_valid_o = out_valid;

  // backpressure reaches the input only with every stage occupied
  a_full_before_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (item_valid_q && geom_valid && square_valid && out_valid))
    else $error("input stalled while a pipeline stage is empty");

  // a delta below the bound must survive truncation to the multiplier width
  a_delta_below_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (geom_valid && !geom.far) |->
      (geom.d[0] < geom.lim && geom.d[1] < geom.lim && geom.d[2] < geom.lim))
    else $error("near delta not below bound");

  a_square_below_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (square_valid && !square.far) |->
      (square.sq[0] < square.lim_sq && square.sq[1] < square.lim_sq
       && square.sq[2] < square.lim_sq))
    else $error("near square not below squared bound");

  a_unknown_kind_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (square_valid && adv_out && square.kind != sbo_pkg::KIND_SPHERE_SPHERE
     && square.kind != sbo_pkg::KIND_BOX_BOX
     && square.kind != sbo_pkg::KIND_SPHERE_BOX) |=> !overlap_o)
    else $error("unknown pair kind reported an overlap");

endmodule

`default_nettype wire

// ===== rtl/core/sbo_geom.sv =====
// Geometry stage: per-axis deltas, sphere-box clamp distance, bounds and box test.
// Depends on sbo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbo_geom (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          valid_i,
  input  wire sbo_pkg::item_t item_i,
  output logic               valid_o,
  output sbo_pkg::geom_t     geom_o
);

  logic           valid_q;
  sbo_pkg::geom_t geom_q, geom_d;

  always_comb begin
    logic [sbo_pkg::DIFF_W-1:0]  ca2, cb2, diff;
    logic [sbo_pkg::ADIFF_W-1:0] adiff;
    logic [sbo_pkg::SIZE_W-1:0]  la, lb, ra, rb;
    logic [sbo_pkg::CMP_W-1:0]   adiff_c, reach_c, ext_c, dsb, dsel, lim_c;
    logic [sbo_pkg::LIM_W-1:0]   ra2, rb2, lim;
    logic                        box_hit, far;

    ra  = item_i.a_size[sbo_pkg::SIZE_W-1:0];
    rb  = item_i.b_size[sbo_pkg::SIZE_W-1:0];
    // zero radius counts as one LSB
    if (ra == '0) begin
      ra = sbo_pkg::SIZE_W'(1);
    end
    if (rb == '0) begin
      rb = sbo_pkg::SIZE_W'(1);
    end
    ra2 = {1'b0, ra, 1'b0};
    rb2 = {1'b0, rb, 1'b0};
    if (item_i.kind == sbo_pkg::KIND_SPHERE_SPHERE) begin
      lim = ra2 + rb2;
    end else begin
      lim = ra2;
    end
    lim_c = sbo_pkg::CMP_W'(lim);

    box_hit = 1'b1;
    far     = 1'b0;
    geom_d  = '0;
    for (int i = 0; i < sbo_pkg::NUM_AXES; i++) begin
      ca2   = {item_i.a_c[i][sbo_pkg::COORD_W-1], item_i.a_c[i], 1'b0};
      cb2   = {item_i.b_c[i][sbo_pkg::COORD_W-1], item_i.b_c[i], 1'b0};
      diff  = ca2 - cb2;
      adiff = diff[sbo_pkg::DIFF_W-1] ? sbo_pkg::ADIFF_W'(cb2 - ca2)
                                      : diff[sbo_pkg::ADIFF_W-1:0];
      la    = item_i.a_size[i*sbo_pkg::SIZE_W +: sbo_pkg::SIZE_W];
      lb    = item_i.b_size[i*sbo_pkg::SIZE_W +: sbo_pkg::SIZE_W];
      adiff_c = sbo_pkg::CMP_W'(adiff);
      reach_c = sbo_pkg::CMP_W'(la) + sbo_pkg::CMP_W'(lb);
      if (adiff_c > reach_c) begin
        box_hit = 1'b0;
      end
      // box is symmetric about its centre: distance to the clamped point is
      // the part of the delta that lies beyond the half-extent
      ext_c = sbo_pkg::CMP_W'(lb);
      dsb   = (adiff_c > ext_c) ? adiff_c - ext_c : '0;
      dsel  = (item_i.kind == sbo_pkg::KIND_SPHERE_BOX) ? dsb : adiff_c;
      if (dsel >= lim_c) begin
        far = 1'b1;
      end
      geom_d.d[i] = dsel[sbo_pkg::LIM_W-1:0];
    end
    geom_d.kind    = item_i.kind;
    geom_d.box_hit = box_hit;
    geom_d.far     = far;
    geom_d.lim     = lim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      geom_q <= geom_d;
    end
  end

  assign valid_o = valid_q;
  assign geom_o  = geom_q;

endmodule

`default_nettype wire

// ===== rtl/core/sbo_square.sv =====
// Square stage: squares of the three per-axis deltas (clamped for sphere-box pairs) and of the distance bound.
// Depends on sbo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbo_square (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          valid_i,
  input  wire sbo_pkg::geom_t geom_i,
  output logic               valid_o,
  output sbo_pkg::square_t   square_o
);

  logic             valid_q;
  sbo_pkg::square_t square_q, square_d;

  always_comb begin
    square_d         = '0;
    square_d.kind    = geom_i.kind;
    square_d.box_hit = geom_i.box_hit;
    square_d.far     = geom_i.far;
    for (int i = 0; i < sbo_pkg::NUM_AXES; i++) begin
      square_d.sq[i] = sbo_pkg::SQ_W'(geom_i.d[i]) * sbo_pkg::SQ_W'(geom_i.d[i]);
    end
    square_d.lim_sq = sbo_pkg::SQ_W'(geom_i.lim) * sbo_pkg::SQ_W'(geom_i.lim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      square_q <= square_d;
    end
  end

  assign valid_o  = valid_q;
  assign square_o = square_q;

endmodule

`default_nettype wire

// ===== rtl/core/sbo_decide.sv =====
// Decision stage: sum of squares against squared bound, select by pair kind.
// Holds the result register. Depends on sbo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbo_decide (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          valid_i,
  input  wire sbo_pkg::square_t square_i,
  output logic               valid_o,
  output logic               overlap_o
);

  logic                     valid_q;
  logic                     overlap_q, overlap_d;
  logic [sbo_pkg::SUM_W-1:0] sum;

  always_comb begin
    sum = sbo_pkg::SUM_W'(square_i.sq[0]) + sbo_pkg::SUM_W'(square_i.sq[1])
        + sbo_pkg::SUM_W'(square_i.sq[2]);
    unique case (square_i.kind) inside
      sbo_pkg::KIND_BOX_BOX: begin
        overlap_d = square_i.box_hit;
      end
      sbo_pkg::KIND_SPHERE_SPHERE, sbo_pkg::KIND_SPHERE_BOX: begin
        overlap_d = !square_i.far && (sum < sbo_pkg::SUM_W'(square_i.lim_sq));
      end
      default: begin
        overlap_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      overlap_q <= overlap_d;
    end
  end

  assign valid_o   = valid_q;
  assign overlap_o = overlap_q;

endmodule

`default_nettype wire
